// ===== rtl/p2p_pkg.sv =====
// ----------------------------------------------------------------------------
// p2p_pkg
// Shared constants and types of the point-to-plane projection pipeline.
// ----------------------------------------------------------------------------
package p2p_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 12 * COORD_W;
	localparam int OUT_W     = 3 * COORD_W + 1;
	localparam int OUT_BYTES = (OUT_W + 7) / 8;

	// widths of the exact intermediate values
	localparam int N_W    = 2 * COORD_W + 1;   // cross product component
	localparam int D_W    = COORD_W + 1;       // point minus origin
	localparam int DOT_W  = N_W + D_W + 2;     // d.n
	localparam int NN_W   = 2 * N_W + 2;       // n.n
	localparam int NUM_W  = DOT_W + N_W;       // d.n * n_i
	localparam int QBITS  = 48;                // quotient bits kept before clamp

	typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== rtl/point_to_plane_projection.sv =====
// ----------------------------------------------------------------------------
// point_to_plane_projection
// Orthogonal projection of a Q16.16 point onto a plane given by an origin
// and two spanning vectors, with saturation and a degenerate flag.
// ----------------------------------------------------------------------------
// pipeline: 9 arithmetic stages, 49-stage divider, output register
// throughput: one request per cycle, the whole pipe stalls on back-pressure
// reset: arst_n clears all valid bits, payload registers are not reset
module point_to_plane_projection
	import p2p_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// point_x, point_y, point_z, origin_x..z, span_a_x..z, span_b_x..z
	input  logic [IN_W-1:0]        s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// proj_x, proj_y, proj_z, degenerate or saturated flag, zero fill
	output logic [OUT_BYTES*8-1:0] m_axis_tdata
);

	localparam int NUMX_W = NUM_W + 2;
	localparam int DEN_W  = NN_W + 1;
	localparam int TAG_W  = COORD_W + 2;   // point coord, sign, singular
	localparam int PP_W   = 2 * COORD_W + 2;
	localparam int DCH_W  = 34;
	localparam int NCH_W  = 33;
	localparam int DM_W   = 3 * DCH_W;
	localparam int NM_W   = 2 * NCH_W;
	localparam int PPW_W  = DCH_W + NCH_W;
	localparam int ROW_W  = DCH_W + NM_W + 1;

	logic en;
	logic ov_q;
	assign en            = !ov_q || m_axis_tready;
	assign s_axis_tready = en;

	coord_t p_in [3], o_in [3], a_in [3], b_in [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_in[i] = s_axis_tdata[i*COORD_W +: COORD_W];
			o_in[i] = s_axis_tdata[(3+i)*COORD_W +: COORD_W];
			a_in[i] = s_axis_tdata[(6+i)*COORD_W +: COORD_W];
			b_in[i] = s_axis_tdata[(9+i)*COORD_W +: COORD_W];
		end
	end

	// s1: cross products and d
	logic v_s1;
	logic signed [2*COORD_W-1:0] m1_s1 [3], m2_s1 [3];
	logic signed [D_W-1:0]       d_s1 [3];
	coord_t                      p_s1 [3];
	// s2: normal
	logic v_s2;
	logic signed [N_W-1:0] n_s2 [3];
	logic signed [D_W-1:0] d_s2 [3];
	coord_t                p_s2 [3];
	// s3: partial products, n split at bit 32
	logic v_s3;
	logic signed [PP_W-1:0] dnl_s3 [3], dnh_s3 [3], nlh_s3 [3], nhh_s3 [3];
	logic [2*COORD_W-1:0]   nll_s3 [3];
	logic signed [N_W-1:0]  n_s3 [3];
	coord_t                 p_s3 [3];
	// s4: per-lane products
	logic v_s4;
	logic signed [N_W+D_W-1:0] dn_s4 [3];
	logic [2*N_W-1:0]          nn_s4 [3];
	logic signed [N_W-1:0]     n_s4 [3];
	coord_t                    p_s4 [3];
	// s5: sums
	logic v_s5;
	logic signed [DOT_W-1:0] dot_s5;
	logic [NN_W-1:0]         nn_s5;
	logic signed [N_W-1:0]   n_s5 [3];
	coord_t                  p_s5 [3];
	// s6: magnitudes
	logic v_s6;
	logic [DM_W-1:0]  dm_s6;
	logic [NM_W-1:0]  nm_s6 [3];
	logic             sg_s6 [3];
	logic [NN_W-1:0]  nn_s6, nn_s7, nn_s8, nn_s9;
	coord_t           p_s6 [3], p_s7 [3], p_s8 [3], p_s9 [3];
	// s7..s9: wide product dot*n_i from 34 x 33 partial products
	logic v_s7, v_s8, v_s9;
	logic [PPW_W-1:0] pp_s7 [3][3][2];
	logic [ROW_W-1:0] row_s8 [3][3];
	logic             sg_s7 [3], sg_s8 [3], sg_s9 [3];
	logic [NUM_W-1:0] num_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m1_s1[i] <= a_in[(i+1)%3] * b_in[(i+2)%3];
				m2_s1[i] <= a_in[(i+2)%3] * b_in[(i+1)%3];
				d_s1[i]  <= D_W'(p_in[i]) - D_W'(o_in[i]);
				p_s1[i]  <= p_in[i];

				n_s2[i] <= N_W'(m1_s1[i]) - N_W'(m2_s1[i]);
				d_s2[i] <= d_s1[i];
				p_s2[i] <= p_s1[i];

				dnl_s3[i] <= PP_W'(signed'({1'b0, n_s2[i][COORD_W-1:0]}))
					* PP_W'(d_s2[i]);
				dnh_s3[i] <= PP_W'(signed'(n_s2[i][N_W-1:COORD_W])) * PP_W'(d_s2[i]);
				nll_s3[i] <= (2*COORD_W)'(n_s2[i][COORD_W-1:0])
					* (2*COORD_W)'(n_s2[i][COORD_W-1:0]);
				nlh_s3[i] <= PP_W'(signed'({1'b0, n_s2[i][COORD_W-1:0]}))
					* PP_W'(signed'(n_s2[i][N_W-1:COORD_W]));
				nhh_s3[i] <= PP_W'(signed'(n_s2[i][N_W-1:COORD_W]))
					* PP_W'(signed'(n_s2[i][N_W-1:COORD_W]));
				n_s3[i]   <= n_s2[i];
				p_s3[i]   <= p_s2[i];

				dn_s4[i] <= ((N_W+D_W)'(dnh_s3[i]) <<< COORD_W) + (N_W+D_W)'(dnl_s3[i]);
				nn_s4[i] <= ((2*N_W)'(nhh_s3[i]) << (2*COORD_W))
					+ ((2*N_W)'(nlh_s3[i]) << (COORD_W+1)) + (2*N_W)'(nll_s3[i]);
				n_s4[i]  <= n_s3[i];
				p_s4[i]  <= p_s3[i];

				n_s5[i] <= n_s4[i];
				p_s5[i] <= p_s4[i];
			end
			dot_s5 <= DOT_W'(dn_s4[0]) + DOT_W'(dn_s4[1]) + DOT_W'(dn_s4[2]);
			nn_s5  <= NN_W'(nn_s4[0]) + NN_W'(nn_s4[1]) + NN_W'(nn_s4[2]);

			dm_s6 <= dot_s5[DOT_W-1] ? DM_W'(-dot_s5) : DM_W'(dot_s5);
			nn_s6 <= nn_s5;
			for (int i = 0; i < 3; i++) begin
				sg_s6[i] <= n_s5[i][N_W-1] ^ dot_s5[DOT_W-1];
				nm_s6[i] <= n_s5[i][N_W-1] ? NM_W'(-n_s5[i]) : NM_W'(n_s5[i]);
				p_s6[i]  <= p_s5[i];
			end

			// dot split in 34-bit chunks, n in 33-bit chunks
			nn_s7 <= nn_s6;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 2; k++) begin
						pp_s7[i][j][k] <= PPW_W'(dm_s6[j*DCH_W +: DCH_W])
							* PPW_W'(nm_s6[i][k*NCH_W +: NCH_W]);
					end
				end
				sg_s7[i] <= sg_s6[i] && (dm_s6 != '0) && (nm_s6[i] != '0);
				p_s7[i]  <= p_s6[i];
			end

			nn_s8 <= nn_s7;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					row_s8[i][j] <= ROW_W'(pp_s7[i][j][0]) + (ROW_W'(pp_s7[i][j][1]) << NCH_W);
				end
				sg_s8[i] <= sg_s7[i];
				p_s8[i]  <= p_s7[i];
			end

			nn_s9 <= nn_s8;
			for (int i = 0; i < 3; i++) begin
				num_s9[i] <= NUM_W'(row_s8[i][0]) + (NUM_W'(row_s8[i][1]) << DCH_W)
					+ (NUM_W'(row_s8[i][2]) << (2*DCH_W));
				sg_s9[i]  <= sg_s8[i];
				p_s9[i]   <= p_s8[i];
			end
		end
	end

	// rounded quotient (2|num| + nn) / (2 nn)
	logic             dv_out [3];
	logic [QBITS-1:0] dq     [3];
	logic             dbig   [3];
	logic [TAG_W-1:0] dtag   [3];
	logic             sing_s9;
	assign sing_s9 = (nn_s9 == '0);

	for (genvar i = 0; i < 3; i++) begin : g_div
		p2p_divider #(.NUM_BITS(NUMX_W), .DEN_BITS(DEN_W), .TAG_W(TAG_W)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_s9),
			.num      ({1'b0, num_s9[i], 1'b0} + NUMX_W'(nn_s9)),
			.den      ({nn_s9, 1'b0}),
			.tag_in   ({sing_s9, sg_s9[i], p_s9[i]}),
			.out_valid(dv_out[i]),
			.quo      (dq[i]),
			.big      (dbig[i]),
			.tag_out  (dtag[i])
		);
	end

	// final sum, saturation, output register
	logic signed [QBITS+1:0] r    [3];
	coord_t                  rs   [3];
	logic                    sat  [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dbig[i] || dq[i][QBITS-1]) begin
				r[i] = dtag[i][COORD_W] ? (QBITS+2)'(48'h7FFF_FFFF_FFFF)
					: -(QBITS+2)'(48'h7FFF_FFFF_FFFF);
			end else if (dtag[i][COORD_W]) begin
				r[i] = (QBITS+2)'(signed'(dtag[i][COORD_W-1:0]))
					+ (QBITS+2)'({2'b00, dq[i]});
			end else begin
				r[i] = (QBITS+2)'(signed'(dtag[i][COORD_W-1:0]))
					- (QBITS+2)'({2'b00, dq[i]});
			end
			if (r[i] > (QBITS+2)'(32'sh7FFF_FFFF)) begin
				rs[i] = 32'sh7FFF_FFFF; sat[i] = 1'b1;
			end else if (r[i] < -(QBITS+2)'(33'sh0_8000_0000)) begin
				rs[i] = 32'sh8000_0000; sat[i] = 1'b1;
			end else begin
				rs[i] = r[i][COORD_W-1:0]; sat[i] = 1'b0;
			end
		end
	end

	logic sing_out;
	assign sing_out = dtag[0][COORD_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= dv_out[0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (sing_out) begin
				m_axis_tdata <= (OUT_BYTES*8)'({1'b1, 96'b0});
			end else begin
				m_axis_tdata <= (OUT_BYTES*8)'({sat[0] | sat[1] | sat[2], rs[2], rs[1], rs[0]});
			end
		end
	end
	assign m_axis_tvalid = ov_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under back-pressure");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dv_out[0] == dv_out[1] && dv_out[1] == dv_out[2])
		else $error("divider lanes out of step");
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

endmodule

// ===== rtl/p2p_divider.sv =====
// ----------------------------------------------------------------------------
// p2p_divider
// Pipelined restoring divider, one quotient bit per stage, with stall.
// Quotient bits above QBITS are folded into an overflow flag.
// ----------------------------------------------------------------------------
module p2p_divider
	import p2p_pkg::*;
#(
	parameter int NUM_BITS = NUM_W + 2,
	parameter int DEN_BITS = NN_W + 1,
	parameter int TAG_W    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	input  logic [TAG_W-1:0]    tag_in,
	output logic                out_valid,
	output logic [QBITS-1:0]    quo,
	output logic                big,
	output logic [TAG_W-1:0]    tag_out
);

	localparam int STAGES = QBITS;
	localparam int REM_W  = DEN_BITS + 1;

	logic [STAGES:0]               v_s;
	logic [NUM_BITS-1:0]           n_s   [STAGES+1];
	logic [DEN_BITS-1:0]           d_s   [STAGES+1];
	logic [REM_W-1:0]              r_s   [STAGES+1];
	logic [QBITS-1:0]              q_s   [STAGES+1];
	logic                          b_s   [STAGES+1];
	logic [TAG_W-1:0]              t_s   [STAGES+1];

	// stage 0: high part of numerator must be below den, else big is set
	logic [NUM_BITS-1:0] hi_part;
	logic                pre_big;
	always_comb begin
		hi_part = num >> QBITS;
		pre_big = ({{(NUM_BITS > DEN_BITS ? 0 : DEN_BITS - NUM_BITS){1'b0}}, hi_part} >=
			{{(NUM_BITS > DEN_BITS ? NUM_BITS - DEN_BITS : 0){1'b0}}, den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= num;
			d_s[0] <= den;
			r_s[0] <= REM_W'(hi_part);
			q_s[0] <= '0;
			b_s[0] <= pre_big;
			t_s[0] <= tag_in;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [REM_W-1:0] sh;
		logic [REM_W:0]   diff;
		always_comb begin
			sh   = {r_s[k][REM_W-2:0], n_s[k][QBITS-1-k]};
			diff = {1'b0, sh} - {2'b00, d_s[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				d_s[k+1] <= d_s[k];
				r_s[k+1] <= diff[REM_W] ? sh : diff[REM_W-1:0];
				q_s[k+1] <= {q_s[k][QBITS-2:0], ~diff[REM_W]};
				b_s[k+1] <= b_s[k];
				t_s[k+1] <= t_s[k];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign quo       = q_s[STAGES];
	assign big       = b_s[STAGES];
	assign tag_out   = t_s[STAGES];

endmodule
